/* sv/jsu_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types and codes for the front end, the item queue and the back end.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_END  = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_NO_OPEN     = 3'd1;
   localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
   localparam logic [2:0] ERR_UNTERM_ESC  = 3'd3;
   localparam logic [2:0] ERR_BAD_ESC     = 3'd4;
   localparam logic [2:0] ERR_BAD_HEX     = 3'd5;
   localparam logic [2:0] ERR_UNTERM_UNI  = 3'd6;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_STR  = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX0 = 3'd3,
      PH_HEX1 = 3'd4,
      PH_HEX2 = 3'd5,
      PH_HEX3 = 3'd6
   } phase_type;

   // One queue entry holds every result that a single input item causes.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;
      logic [1:0] kind;
      logic [2:0] error_code;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* sv/jsu_front.sv */
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Tracks the string phase, decodes escapes and builds at most one queue entry per item.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       end_of_input,
   output logic       push,
   output entry_type  entry
);

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_F = 8'h66;
   localparam logic [7:0] CH_N = 8'h6E;
   localparam logic [7:0] CH_R = 8'h72;
   localparam logic [7:0] CH_T = 8'h74;
   localparam logic [7:0] CH_U = 8'h75;

   phase_type   phase_ff, phase_in;
   logic [11:0] acc_ff, acc_in;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] code_point;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
      end
   end

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
         hex_val = data_byte[3:0];
      end else if ((data_byte >= 8'h61 && data_byte <= 8'h66) ||
                   (data_byte >= 8'h41 && data_byte <= 8'h46)) begin
         hex_val = data_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign code_point = {acc_ff, hex_val};

   always_comb begin
      phase_in         = phase_ff;
      acc_in           = acc_ff;
      entry.byte0      = 8'd0;
      entry.byte1      = 8'd0;
      entry.byte2      = 8'd0;
      entry.count      = 2'd0;
      entry.kind       = KIND_BYTE;
      entry.error_code = ERR_NONE;
      if (end_of_input) begin
         phase_in    = PH_IDLE;
         acc_in      = '0;
         entry.count = 2'd1;
         entry.kind  = KIND_ERR;
         unique case (phase_ff) inside
            PH_STR: entry.error_code = ERR_UNTERM_STR;
            PH_ESC: entry.error_code = ERR_UNTERM_ESC;
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: entry.error_code = ERR_UNTERM_UNI;
            default: entry.error_code = ERR_NO_OPEN;
         endcase
      end else begin
         unique case (phase_ff) inside
            PH_STR: begin
               entry.count = 2'd1;
               if (data_byte == CH_QUOTE) begin
                  phase_in   = PH_IDLE;
                  entry.kind = KIND_END;
               end else if (data_byte == CH_BSLASH) begin
                  phase_in    = PH_ESC;
                  entry.count = 2'd0;
               end else begin
                  entry.byte0 = data_byte;
               end
            end
            PH_ESC: begin
               phase_in    = PH_STR;
               entry.count = 2'd1;
               unique case (data_byte)
                  CH_QUOTE, CH_BSLASH, CH_SLASH: entry.byte0 = data_byte;
                  CH_B: entry.byte0 = 8'h08;
                  CH_F: entry.byte0 = 8'h0C;
                  CH_N: entry.byte0 = 8'h0A;
                  CH_R: entry.byte0 = 8'h0D;
                  CH_T: entry.byte0 = 8'h09;
                  CH_U: begin
                     phase_in    = PH_HEX0;
                     acc_in      = '0;
                     entry.count = 2'd0;
                  end
                  default: begin
                     phase_in         = PH_IDLE;
                     acc_in           = '0;
                     entry.kind       = KIND_ERR;
                     entry.error_code = ERR_BAD_ESC;
                  end
               endcase
            end
            PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
               if (!hex_ok) begin
                  phase_in         = PH_IDLE;
                  acc_in           = '0;
                  entry.count      = 2'd1;
                  entry.kind       = KIND_ERR;
                  entry.error_code = ERR_BAD_HEX;
               end else if (phase_ff != PH_HEX3) begin
                  acc_in = {acc_ff[7:0], hex_val};
                  unique case (phase_ff)
                     PH_HEX0: phase_in = PH_HEX1;
                     PH_HEX1: phase_in = PH_HEX2;
                     default: phase_in = PH_HEX3;
                  endcase
               end else begin
                  phase_in = PH_STR;
                  acc_in   = '0;
                  if (code_point[15:7] == '0) begin
                     entry.count = 2'd1;
                     entry.byte0 = code_point[7:0];
                  end else if (code_point[15:11] == '0) begin
                     entry.count = 2'd2;
                     entry.byte0 = {3'b110, code_point[10:6]};
                     entry.byte1 = {2'b10, code_point[5:0]};
                  end else begin
                     entry.count = 2'd3;
                     entry.byte0 = {4'b1110, code_point[15:12]};
                     entry.byte1 = {2'b10, code_point[11:6]};
                     entry.byte2 = {2'b10, code_point[5:0]};
                  end
               end
            end
            default: begin
               if (data_byte == CH_QUOTE) begin
                  phase_in = PH_STR;
               end else begin
                  phase_in         = PH_IDLE;
                  acc_in           = '0;
                  entry.count      = 2'd1;
                  entry.kind       = KIND_ERR;
                  entry.error_code = ERR_NO_OPEN;
               end
            end
         endcase
      end
   end

   assign push = accept && (entry.count != 2'd0);

endmodule

/* sv/jsu_queue.sv */
// ----------------------------------------------------------------------------
// JSON string unescape item queue
// Short first-in first-out queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head_entry,
   output q_status_type status
);

   entry_type            slots_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry   = slots_ff[rd_ptr_ff];
   assign status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

/* sv/jsu_back.sv */
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Splits each queue entry into result items and holds them in an output register.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  entry_type    head_entry,
   input  q_status_type status,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic [1:0]   rsp_kind,
   output logic [2:0]   rsp_error_code,
   output logic         rsp_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       load, advance, final_one;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff;
   logic [2:0] err_ff;
   logic       last_ff;

   assign load      = !valid_ff || !rsp_stall;
   assign advance   = load && !status.empty;
   assign final_one = (idx_ff == head_entry.count - 2'd1);
   assign pop       = advance && final_one;

   always_comb begin
      valid_in = load ? !status.empty : valid_ff;
      idx_in   = idx_ff;
      if (advance) begin
         idx_in = final_one ? 2'd0 : idx_ff + 2'd1;
      end
      case (idx_ff)
         2'd0:    byte_in = head_entry.byte0;
         2'd1:    byte_in = head_entry.byte1;
         default: byte_in = head_entry.byte2;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_in;
         kind_ff <= head_entry.kind;
         err_ff  <= head_entry.error_code;
         last_ff <= final_one;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_error_code = err_ff;
   assign rsp_last       = last_ff;

endmodule

/* sv/json_string_unescape_top.sv */
// ----------------------------------------------------------------------------
// JSON string unescape top level
// Decodes the bytes of one JSON string literal into raw and UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one input byte per item, or an end-of-input flag.
// The rsp channel carries decoded bytes, an end marker at the closing quote,
// or an error code; rsp_last marks the final result of each input item.
// An input item yields zero to three results, which pass through the queue
// and the output register. One item is taken per cycle while req_stall is
// low; the back end delivers one result per cycle while rsp_stall is low,
// so a unicode escape of three bytes yields three results from one item. A
// four-entry queue between the decoder and the output stage absorbs that
// difference and any rsp_stall; req_stall rises only while it is full.
// Synchronous reset returns the decoder to the idle phase, waiting for an
// opening quote, and empties the queue and the output register.
// While rsp_stall is high the presented result holds and later results wait.
// ----------------------------------------------------------------------------
module json_string_unescape_top import jsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_kind,
   output logic [2:0] rsp_error_code,
   output logic       rsp_last
);

   logic         accept, push, pop;
   entry_type    push_entry, head_entry;
   q_status_type status;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .end_of_input (req_end_of_input),
      .push         (push),
      .entry        (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (status)
   );

   jsu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .status         (status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

   a_end_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END || rsp_kind == KIND_ERR) |-> rsp_last)
      else $error("End or error result not marked last.");

   a_code_only_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERR |-> rsp_error_code == ERR_NONE)
      else $error("Error code set on a non-error result.");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("Result presented right after reset.");

   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !push || pop)
      else $error("Queue written while full.");

endmodule
